>>> hw/rtl/acut_pkg.sv
// ----------------------------------------------------------------------------
// acut_pkg
// Constants shared by the adaptive credit update threshold block: register
// indexes, reset values of the configuration and the arithmetic constants.
// ----------------------------------------------------------------------------
`default_nettype none

package acut_pkg;

  // Configuration register indexes
  typedef logic [2:0] cfg_idx_t;
  localparam cfg_idx_t REG_RECEIVE_DEPTH  = 3'd0;
  localparam cfg_idx_t REG_WINDOW_SAMPLES = 3'd1;
  localparam cfg_idx_t REG_HIGH_RATE      = 3'd2;
  localparam cfg_idx_t REG_LOW_RATE       = 3'd3;
  localparam cfg_idx_t REG_RATIO_MIN      = 3'd4;
  localparam cfg_idx_t REG_RATIO_MAX      = 3'd5;
  localparam cfg_idx_t REG_RATIO_INIT     = 3'd6;

  // Reset values of the configuration registers
  localparam logic [15:0] RST_RECEIVE_DEPTH  = 16'd256;
  localparam logic [15:0] RST_WINDOW_SAMPLES = 16'd16;
  localparam logic [31:0] RST_HIGH_RATE      = 32'd100000;
  localparam logic [31:0] RST_LOW_RATE       = 32'd1000;
  localparam logic [15:0] RST_RATIO_MIN      = 16'd16384;
  localparam logic [15:0] RST_RATIO_MAX      = 16'd49152;
  localparam logic [15:0] RST_RATIO_INIT     = 16'd32768;

  // Milliseconds per second, scales the window sum into items per second
  localparam logic [19:0] MS_PER_SEC = 20'd1000;

  // x/5 == (x * RECIP5) >> RECIP5_SHIFT for every x below 2^22
  localparam logic [19:0] RECIP5       = 20'd838861;
  localparam int unsigned RECIP5_SHIFT = 22;

  // Shared restoring divider: dividend bits, one quotient bit per step
  localparam int unsigned DIV_STEPS = 48;
  localparam int unsigned CNT_W     = $clog2(DIV_STEPS);

endpackage : acut_pkg

`default_nettype wire

>>> hw/rtl/adaptive_credit_update_threshold.sv
// ----------------------------------------------------------------------------
// adaptive_credit_update_threshold
// Rate-adaptive lazy credit update threshold with one shared multiplier and
// one shared bit-serial divider under a small sequencer.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one report per transaction:
//   a received count and a millisecond timestamp. Every report gives exactly
//   one result transaction on the output channel (out_valid / out_stall):
//   the current threshold, the current rate estimate and a window-closed flag.
//   Configuration is written through cfg_we / cfg_index / cfg_wdata; the
//   user must do so only while the block is idle, which the block does
//   not enforce. An index above five is ignored. A report that does not
//   close a window, or closes one with zero elapsed time, goes straight to
//   the output state. A closing report runs the rate division and, when the
//   rate lies strictly between the limits, a second one that interpolates
//   the target ratio; the restoring divider yields one quotient bit per cycle.
//   One report is in work at a time; in_stall is low only while the
//   sequencer is idle, so the next report may enter in the cycle after the
//   previous result is written into the output register.
//   A stalled result stays in the output register; a new report is still
//   accepted and its result waits until the register frees up.
//   Reset (synchronous, rst_n low) loads the default configuration, clears
//   the window and sets ratio and threshold from the default ratio_initial.
// ----------------------------------------------------------------------------
`default_nettype none

module adaptive_credit_update_threshold #(
  parameter int unsigned RATIO_FRAC_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // report input channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [15:0] in_received_count,
  input  wire logic [31:0] in_now_ms,
  // result output channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      out_update_threshold,
  output logic [31:0]      out_rate_estimate,
  output logic             out_window_closed,
  // configuration write port
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_wdata
);

  // Sequencer states
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_OUT  = 4'd1;
  localparam logic [3:0] S_MUL1 = 4'd2;
  localparam logic [3:0] S_DIV  = 4'd3;
  localparam logic [3:0] S_RATE = 4'd4;
  localparam logic [3:0] S_TGT  = 4'd5;
  localparam logic [3:0] S_MUL2 = 4'd6;
  localparam logic [3:0] S_TGT2 = 4'd7;
  localparam logic [3:0] S_SM1  = 4'd8;
  localparam logic [3:0] S_SM2  = 4'd9;
  localparam logic [3:0] S_THR1 = 4'd10;
  localparam logic [3:0] S_THR2 = 4'd11;

  localparam int unsigned DW = acut_pkg::DIV_STEPS;
  localparam int unsigned CW = acut_pkg::CNT_W;

  // Threshold after reset, from the default depth and initial ratio
  localparam logic [31:0] THR_RST_PROD =
    32'(acut_pkg::RST_RECEIVE_DEPTH) * 32'(acut_pkg::RST_RATIO_INIT);
  localparam logic [31:0] THR_RST_SH = THR_RST_PROD >> RATIO_FRAC_BITS;
  localparam logic [15:0] THR_RST =
    (THR_RST_SH[31:16] != 16'd0) ? 16'hFFFF : THR_RST_SH[15:0];

  // Configuration registers
  logic [15:0] depth_r, depth_nxt;
  logic [15:0] need_r, need_nxt;
  logic [31:0] high_r, high_nxt;
  logic [31:0] low_r, low_nxt;
  logic [15:0] rmin_r, rmin_nxt;
  logic [15:0] rmax_r, rmax_nxt;

  // Block state
  logic [31:0] sum_r, sum_nxt;
  logic [15:0] tally_r, tally_nxt;
  logic [31:0] start_r, start_nxt;
  logic [31:0] rate_r, rate_nxt;
  logic [15:0] smooth_r, smooth_nxt;
  logic [15:0] thr_r, thr_nxt;

  // Sequencer and work registers
  logic [3:0]    state_r, state_nxt;
  logic [31:0]   wsum_r, wsum_nxt;
  logic [31:0]   elapsed_r, elapsed_nxt;
  logic          closed_r, closed_nxt;
  logic [15:0]   tgt_r, tgt_nxt;
  logic          div_sel_r, div_sel_nxt;   // 0: rate division, 1: interpolation
  logic [DW-1:0] dvd_r, dvd_nxt;           // dividend, quotient, product
  logic [31:0]   dvs_r, dvs_nxt;
  logic [31:0]   rem_r, rem_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  // Output register
  logic        out_valid_r, out_valid_nxt;
  logic [15:0] out_thr_r, out_thr_nxt;
  logic [31:0] out_rate_r, out_rate_nxt;
  logic        out_closed_r, out_closed_nxt;

  // Combinational helpers
  logic        in_acc;
  logic [32:0] sum_add;
  logic [31:0] sum_sat;
  logic [15:0] tally_inc;
  logic        win_close;
  logic [31:0] mul_a;
  logic [19:0] mul_b;
  logic [51:0] mul_p;
  logic [32:0] rem_sh;
  logic [32:0] rem_dif;
  logic        rem_ge;
  logic        diff_neg;
  logic [15:0] diff_abs;
  logic [18:0] sm_x;
  logic [31:0] thr_sh;
  logic        out_free;

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // Window accumulation for the incoming report
  assign sum_add   = {1'b0, sum_r} + 33'(in_received_count);
  assign sum_sat   = sum_add[32] ? 32'hFFFF_FFFF : sum_add[31:0];
  assign tally_inc = (tally_r == 16'hFFFF) ? tally_r : tally_r + 16'd1;
  assign win_close = (tally_inc >= need_r);

  // Interpolation direction and magnitude
  assign diff_neg = (rmin_r > rmax_r);
  assign diff_abs = diff_neg ? (rmin_r - rmax_r) : (rmax_r - rmin_r);

  // Smoothing numerator 4*old + target
  assign sm_x = {1'b0, smooth_r, 2'b00} + 19'(tgt_r);

  // Threshold scaling of the registered product
  assign thr_sh = dvd_r[31:0] >> RATIO_FRAC_BITS;

  // Shared multiplier operand select
  always_comb begin
    mul_a = 32'd0;
    mul_b = 20'd0;
    case (state_r)
      S_MUL1: begin
        mul_a = wsum_r;
        mul_b = acut_pkg::MS_PER_SEC;
      end
      S_MUL2: begin
        mul_a = rate_r - low_r;
        mul_b = 20'(diff_abs);
      end
      S_SM1: begin
        mul_a = 32'(sm_x);
        mul_b = acut_pkg::RECIP5;
      end
      S_THR1: begin
        mul_a = 32'(depth_r);
        mul_b = 20'(smooth_r);
      end
      default: begin
        mul_a = 32'd0;
        mul_b = 20'd0;
      end
    endcase
  end

  assign mul_p = 52'(mul_a) * 52'(mul_b);

  // Shared divider step: restoring, one quotient bit per cycle
  assign rem_sh  = {rem_r, dvd_r[DW-1]};
  assign rem_ge  = (rem_sh >= {1'b0, dvs_r});
  assign rem_dif = rem_sh - {1'b0, dvs_r};

  // Next-state logic
  always_comb begin
    depth_nxt      = depth_r;
    need_nxt       = need_r;
    high_nxt       = high_r;
    low_nxt        = low_r;
    rmin_nxt       = rmin_r;
    rmax_nxt       = rmax_r;
    sum_nxt        = sum_r;
    tally_nxt      = tally_r;
    start_nxt      = start_r;
    rate_nxt       = rate_r;
    smooth_nxt     = smooth_r;
    thr_nxt        = thr_r;
    state_nxt      = state_r;
    wsum_nxt       = wsum_r;
    elapsed_nxt    = elapsed_r;
    closed_nxt     = closed_r;
    tgt_nxt        = tgt_r;
    div_sel_nxt    = div_sel_r;
    dvd_nxt        = dvd_r;
    dvs_nxt        = dvs_r;
    rem_nxt        = rem_r;
    cnt_nxt        = cnt_r;
    out_valid_nxt  = out_valid_r;
    out_thr_nxt    = out_thr_r;
    out_rate_nxt   = out_rate_r;
    out_closed_nxt = out_closed_r;

    // configuration writes
    if (cfg_we) begin
      case (cfg_index)
        acut_pkg::REG_RECEIVE_DEPTH:  depth_nxt = cfg_wdata[15:0];
        acut_pkg::REG_WINDOW_SAMPLES: need_nxt  = cfg_wdata[15:0];
        acut_pkg::REG_HIGH_RATE:      high_nxt  = cfg_wdata;
        acut_pkg::REG_LOW_RATE:       low_nxt   = cfg_wdata;
        acut_pkg::REG_RATIO_MIN:      rmin_nxt  = cfg_wdata[15:0];
        acut_pkg::REG_RATIO_MAX:      rmax_nxt  = cfg_wdata[15:0];
        // initial ratio only seeds the ratio at reset, from its default
        acut_pkg::REG_RATIO_INIT:     ;
        default: ;
      endcase
    end

    // output register drains
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          closed_nxt = win_close;
          if (win_close) begin
            wsum_nxt    = sum_sat;
            elapsed_nxt = in_now_ms - start_r;
            sum_nxt     = 32'd0;
            tally_nxt   = 16'd0;
            start_nxt   = in_now_ms;
            state_nxt   = ((in_now_ms - start_r) == 32'd0) ? S_OUT : S_MUL1;
          end else begin
            sum_nxt   = sum_sat;
            tally_nxt = tally_inc;
            state_nxt = S_OUT;
          end
        end
      end
      S_MUL1: begin
        dvd_nxt     = mul_p[DW-1:0];
        dvs_nxt     = elapsed_r;
        rem_nxt     = 32'd0;
        cnt_nxt     = '0;
        div_sel_nxt = 1'b0;
        state_nxt   = S_DIV;
      end
      S_DIV: begin
        rem_nxt = rem_ge ? rem_dif[31:0] : rem_sh[31:0];
        dvd_nxt = {dvd_r[DW-2:0], rem_ge};
        cnt_nxt = cnt_r + CW'(1);
        if (cnt_r == CW'(DW - 1)) begin
          state_nxt = div_sel_r ? S_TGT2 : S_RATE;
        end
      end
      S_RATE: begin
        rate_nxt  = (dvd_r[DW-1:32] != '0) ? 32'hFFFF_FFFF : dvd_r[31:0];
        state_nxt = S_TGT;
      end
      S_TGT: begin
        if (rate_r >= high_r) begin
          tgt_nxt   = rmax_r;
          state_nxt = S_SM1;
        end else if (rate_r <= low_r) begin
          tgt_nxt   = rmin_r;
          state_nxt = S_SM1;
        end else begin
          state_nxt = S_MUL2;
        end
      end
      S_MUL2: begin
        dvd_nxt     = mul_p[DW-1:0];
        dvs_nxt     = high_r - low_r;
        rem_nxt     = 32'd0;
        cnt_nxt     = '0;
        div_sel_nxt = 1'b1;
        state_nxt   = S_DIV;
      end
      S_TGT2: begin
        // quotient is below the ratio span, so 16 bits hold it
        tgt_nxt   = diff_neg ? (rmin_r - dvd_r[15:0]) : (rmin_r + dvd_r[15:0]);
        state_nxt = S_SM1;
      end
      S_SM1: begin
        dvd_nxt   = mul_p[DW-1:0];
        state_nxt = S_SM2;
      end
      S_SM2: begin
        smooth_nxt = dvd_r[acut_pkg::RECIP5_SHIFT +: 16];
        state_nxt  = S_THR1;
      end
      S_THR1: begin
        dvd_nxt   = mul_p[DW-1:0];
        state_nxt = S_THR2;
      end
      S_THR2: begin
        thr_nxt   = (thr_sh[31:16] != 16'd0) ? 16'hFFFF : thr_sh[15:0];
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_thr_nxt    = thr_r;
          out_rate_nxt   = rate_r;
          out_closed_nxt = closed_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Registers with reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r     <= acut_pkg::RST_RECEIVE_DEPTH;
      need_r      <= acut_pkg::RST_WINDOW_SAMPLES;
      high_r      <= acut_pkg::RST_HIGH_RATE;
      low_r       <= acut_pkg::RST_LOW_RATE;
      rmin_r      <= acut_pkg::RST_RATIO_MIN;
      rmax_r      <= acut_pkg::RST_RATIO_MAX;
      sum_r       <= 32'd0;
      tally_r     <= 16'd0;
      start_r     <= 32'd0;
      rate_r      <= 32'd0;
      smooth_r    <= acut_pkg::RST_RATIO_INIT;
      thr_r       <= THR_RST;
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      depth_r     <= depth_nxt;
      need_r      <= need_nxt;
      high_r      <= high_nxt;
      low_r       <= low_nxt;
      rmin_r      <= rmin_nxt;
      rmax_r      <= rmax_nxt;
      sum_r       <= sum_nxt;
      tally_r     <= tally_nxt;
      start_r     <= start_nxt;
      rate_r      <= rate_nxt;
      smooth_r    <= smooth_nxt;
      thr_r       <= thr_nxt;
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload and work registers, no reset
  always_ff @(posedge clk) begin
    wsum_r       <= wsum_nxt;
    elapsed_r    <= elapsed_nxt;
    closed_r     <= closed_nxt;
    tgt_r        <= tgt_nxt;
    div_sel_r    <= div_sel_nxt;
    dvd_r        <= dvd_nxt;
    dvs_r        <= dvs_nxt;
    rem_r        <= rem_nxt;
    cnt_r        <= cnt_nxt;
    out_thr_r    <= out_thr_nxt;
    out_rate_r   <= out_rate_nxt;
    out_closed_r <= out_closed_nxt;
  end

  assign out_valid            = out_valid_r;
  assign out_update_threshold = out_thr_r;
  assign out_rate_estimate    = out_rate_r;
  assign out_window_closed    = out_closed_r;

  // Assertions
  a_div_partial_rem : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (rem_r < dvs_r))
    else $error("divider remainder not below divisor");

  a_div_full_length : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && state_nxt != S_DIV) |-> (cnt_r == CW'(DW - 1)))
    else $error("divider left before all quotient bits");

  a_out_from_seq : assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $rose(out_valid_r)) |-> ($past(state_r) == S_OUT))
    else $error("result loaded outside the output state");

  a_thr_update : assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && (thr_r != $past(thr_r))) |-> ($past(state_r) == S_THR2))
    else $error("threshold changed outside its update step");

endmodule : adaptive_credit_update_threshold

`default_nettype wire
